FILE: src/directed_cycle_finder_unit_macros.svh
// ----------------------------------------------------------------------------
// directed_cycle_finder_unit_macros
// Assertion macros for the directed cycle finder.
// ----------------------------------------------------------------------------
`ifndef DIRECTED_CYCLE_FINDER_UNIT_MACROS_SVH
`define DIRECTED_CYCLE_FINDER_UNIT_MACROS_SVH
// Antecedent implies consequent in the same cycle.
`define DCF_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
// Antecedent implies consequent in the next cycle.
`define DCF_ASSERT_NXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

FILE: src/dcf_pkg.sv
// ----------------------------------------------------------------------------
// dcf_pkg
// Shared constants of the directed cycle finder.
// ----------------------------------------------------------------------------
package dcf_pkg;
    localparam int VERTEX_LIMIT = 64;
    localparam int VW = 7;
    localparam logic [1:0] COL_WHITE = 2'd0;
    localparam logic [1:0] COL_GRAY  = 2'd1;
    localparam logic [1:0] COL_BLACK = 2'd2;
endpackage

FILE: src/directed_cycle_finder_unit.sv
// ----------------------------------------------------------------------------
// directed_cycle_finder_unit
// Bit adjacency matrix with a sequenced depth-first cycle search.
// ----------------------------------------------------------------------------
// channel  dir  tdata                     tuser         tlast
// s_axis   in   src_vertex, dst_vertex    mode          -
// m_axis   out  vertex_out                cycle_found   last_item
// cfg      in   cfg_data: vertex_count    -             -
// An edge transfer is read-modify-write: the row is read, then written back.
// A run has an init step, a read and check per root, and per tree vertex a
// row read, a scan of positions up to n, an eval per set bit and a pop; then
// a path trace, result items sent subject to output stalls, and a clear pass
// over MAX_V rows. Reset starts the same clear pass; no s_axis transfer is
// taken before it ends. Colour valid bits reset at run start.
// ----------------------------------------------------------------------------
`include "directed_cycle_finder_unit_macros.svh"
module directed_cycle_finder_unit #(
    parameter int MAX_V = dcf_pkg::VERTEX_LIMIT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // src_vertex, dst_vertex
    input  logic        s_axis_tuser,  // mode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,  // vertex_out
    output logic        m_axis_tuser,  // cycle_found
    output logic        m_axis_tlast,  // last_item
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [6:0]  cfg_data       // vertex_count
);
    localparam int AW = $clog2(MAX_V);
    localparam int VW = dcf_pkg::VW;

    typedef enum logic [3:0] {
        S_IDLE, S_INIT, S_ROOT, S_RCHK, S_ROW, S_SCAN, S_EVAL, S_POP,
        S_PATH, S_PWAIT, S_EMIT, S_EOUT, S_CLEAR
    } state_t;

    state_t state_reg;
    logic [VW-1:0] count_reg;
    logic [VW-1:0] n_reg;
    logic [VW-1:0] root_reg;
    logic [VW-1:0] depth_reg;
    logic [AW-1:0] u_reg;
    logic [VW-1:0] k_reg;
    logic found_reg;
    logic [AW-1:0] cstart_reg, cend_reg, cur_reg;
    logic [VW-1:0] plen_reg, emit_reg;
    logic [MAX_V-1:0] row_reg;
    logic [MAX_V-1:0] col_vld_reg;
    logic col_ok_reg;
    logic [VW-1:0] clr_reg;
    logic out_v_reg, out_f_reg, out_l_reg;
    logic [VW-1:0] out_d_reg;
    logic out_load, out_f_next, out_l_next;
    logic [VW-1:0] out_d_next;

    // memories
    logic adj_we; logic [AW-1:0] adj_wa, adj_ra; logic [MAX_V-1:0] adj_wd, adj_rd;
    logic col_we; logic [AW-1:0] col_wa, col_ra; logic [1:0] col_wd, col_rd;
    logic par_we; logic [AW-1:0] par_wa, par_ra; logic [AW-1:0] par_wd, par_rd;
    logic stk_we; logic [AW-1:0] stk_wa, stk_ra; logic [2*VW-1:0] stk_wd, stk_rd;
    logic pth_we; logic [AW-1:0] pth_wa, pth_ra; logic [AW-1:0] pth_wd, pth_rd;

    dcf_ram #(.DEPTH(MAX_V), .WIDTH(MAX_V)) u_adj (.clk(clk), .we(adj_we),
        .waddr(adj_wa), .wdata(adj_wd), .raddr(adj_ra), .rdata(adj_rd));
    dcf_ram #(.DEPTH(MAX_V), .WIDTH(2)) u_col (.clk(clk), .we(col_we),
        .waddr(col_wa), .wdata(col_wd), .raddr(col_ra), .rdata(col_rd));
    dcf_ram #(.DEPTH(MAX_V), .WIDTH(AW)) u_par (.clk(clk), .we(par_we),
        .waddr(par_wa), .wdata(par_wd), .raddr(par_ra), .rdata(par_rd));
    dcf_ram #(.DEPTH(MAX_V), .WIDTH(2*VW)) u_stk (.clk(clk), .we(stk_we),
        .waddr(stk_wa), .wdata(stk_wd), .raddr(stk_ra), .rdata(stk_rd));
    dcf_ram #(.DEPTH(MAX_V), .WIDTH(AW)) u_pth (.clk(clk), .we(pth_we),
        .waddr(pth_wa), .wdata(pth_wd), .raddr(pth_ra), .rdata(pth_rd));

    logic in_mode;
    logic [VW-1:0] in_src, in_dst;
    logic src_ok, dst_ok, edge_xfer, edge_wait;
    assign in_mode = s_axis_tuser;
    assign in_src  = s_axis_tdata[6:0];
    assign in_dst  = s_axis_tdata[13:7];
    assign src_ok  = in_src >= VW'(1) && in_src <= VW'(MAX_V);
    assign dst_ok  = in_dst >= VW'(1) && in_dst <= VW'(MAX_V);

    // edge load is read-modify-write: read row, then OR in the bit
    logic          ld_pend_reg;
    logic [AW-1:0] ld_row_reg;
    logic [AW-1:0] ld_bit_reg;
    assign edge_wait = ld_pend_reg;
    assign s_axis_tready = state_reg == S_IDLE && !edge_wait && !out_v_reg;
    assign edge_xfer = s_axis_tvalid && s_axis_tready && !in_mode;
    assign cfg_ready = 1'b1;

    logic [1:0] col_eff;
    assign col_eff = col_ok_reg ? col_rd : dcf_pkg::COL_WHITE;

    logic out_take;
    assign out_take = m_axis_tready && out_v_reg;

    always_comb
    begin
        adj_we = ld_pend_reg; adj_wa = ld_row_reg;
        adj_wd = adj_rd | (MAX_V'(1) << ld_bit_reg);
        adj_ra = AW'(in_src - VW'(1));
        col_we = 1'b0; col_wa = k_reg[AW-1:0]; col_wd = dcf_pkg::COL_GRAY;
        col_ra = k_reg[AW-1:0];
        par_we = 1'b0; par_wa = k_reg[AW-1:0]; par_wd = u_reg; par_ra = cur_reg;
        stk_we = 1'b0; stk_wa = AW'(depth_reg - VW'(1));
        stk_wd = {VW'(u_reg), k_reg + VW'(1)};
        stk_ra = AW'(depth_reg - VW'(2));
        pth_we = 1'b0; pth_wa = plen_reg[AW-1:0]; pth_wd = cur_reg;
        pth_ra = AW'(plen_reg - VW'(1) - emit_reg);
        out_load = 1'b0; out_f_next = 1'b1;
        out_d_next = VW'(pth_rd) + VW'(1);
        out_l_next = emit_reg == plen_reg - VW'(1);
        unique case (state_reg)
            S_ROOT:
            begin
                col_ra = root_reg[AW-1:0];
            end
            S_RCHK:
            begin
                if (col_eff == dcf_pkg::COL_WHITE)
                begin
                    col_we = 1'b1; col_wa = root_reg[AW-1:0];
                    adj_ra = root_reg[AW-1:0];
                end
            end
            S_SCAN:
            begin
                if (k_reg >= n_reg)
                begin
                    col_we = 1'b1; col_wa = u_reg; col_wd = dcf_pkg::COL_BLACK;
                end
            end
            S_EVAL:
            begin
                if (col_eff == dcf_pkg::COL_WHITE)
                begin
                    par_we = 1'b1;
                    col_we = 1'b1;
                    adj_ra = k_reg[AW-1:0];
                    if (depth_reg < VW'(MAX_V))
                    begin
                        stk_we = 1'b1;
                    end
                end
            end
            S_POP:
            begin
                adj_ra = stk_rd[VW+AW-1:VW];
            end
            S_PATH:
            begin
                pth_we = 1'b1;
            end
            S_EMIT:
            begin
                if (plen_reg == '0 && (!out_v_reg || out_take))
                begin
                    out_load = 1'b1; out_f_next = 1'b0;
                    out_d_next = '0; out_l_next = 1'b1;
                end
            end
            S_EOUT:
            begin
                if (!out_v_reg || out_take)
                begin
                    out_load = 1'b1;
                end
            end
            S_CLEAR:
            begin
                adj_we = 1'b1; adj_wa = clr_reg[AW-1:0]; adj_wd = '0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            clr_reg     <= '0;
            count_reg   <= VW'(64);
            n_reg       <= '0;
            root_reg    <= '0;
            depth_reg   <= '0;
            u_reg       <= '0;
            k_reg       <= '0;
            found_reg   <= 1'b0;
            cstart_reg  <= '0;
            cend_reg    <= '0;
            cur_reg     <= '0;
            plen_reg    <= '0;
            emit_reg    <= '0;
            row_reg     <= '0;
            col_vld_reg <= '0;
            col_ok_reg  <= 1'b0;
            ld_pend_reg <= 1'b0;
            ld_row_reg  <= '0;
            ld_bit_reg  <= '0;
            out_v_reg   <= 1'b0;
            out_f_reg   <= 1'b0;
            out_d_reg   <= '0;
            out_l_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                count_reg <= cfg_data;
            end
            ld_pend_reg <= edge_xfer && src_ok && dst_ok;
            if (edge_xfer)
            begin
                ld_row_reg <= AW'(in_src - VW'(1));
                ld_bit_reg <= AW'(in_dst - VW'(1));
            end
            col_ok_reg <= col_vld_reg[col_ra];
            if (state_reg == S_INIT)
            begin
                col_vld_reg <= '0;
            end
            else if (col_we)
            begin
                col_vld_reg[col_wa] <= 1'b1;
            end
            if (out_load)
            begin
                out_v_reg <= 1'b1;
                out_f_reg <= out_f_next;
                out_d_reg <= out_d_next;
                out_l_reg <= out_l_next;
            end
            else if (out_take)
            begin
                out_v_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (s_axis_tvalid && s_axis_tready && in_mode)
                    begin
                        n_reg <= count_reg > VW'(MAX_V) ? VW'(MAX_V) : count_reg;
                        state_reg <= S_INIT;
                    end
                end
                S_INIT:
                begin
                    found_reg <= 1'b0;
                    root_reg  <= '0;
                    depth_reg <= '0;
                    state_reg <= S_ROOT;
                end
                S_ROOT:
                begin
                    if (root_reg >= n_reg)
                    begin
                        plen_reg  <= '0;
                        emit_reg  <= '0;
                        cur_reg   <= cend_reg;
                        state_reg <= found_reg ? S_PATH : S_EMIT;
                    end
                    else
                    begin
                        state_reg <= S_RCHK;
                    end
                end
                S_RCHK:
                begin
                    root_reg <= root_reg + VW'(1);
                    if (col_eff == dcf_pkg::COL_WHITE)
                    begin
                        u_reg     <= root_reg[AW-1:0];
                        k_reg     <= '0;
                        depth_reg <= VW'(1);
                        state_reg <= S_ROW;
                    end
                    else
                    begin
                        state_reg <= S_ROOT;
                    end
                end
                S_ROW:
                begin
                    row_reg   <= adj_rd;
                    state_reg <= S_SCAN;
                end
                S_SCAN:
                begin
                    if (k_reg >= n_reg)
                    begin
                        depth_reg <= depth_reg - VW'(1);
                        state_reg <= (depth_reg == VW'(1)) ? S_ROOT : S_POP;
                    end
                    else if (row_reg[k_reg[AW-1:0]])
                    begin
                        state_reg <= S_EVAL;
                    end
                    else
                    begin
                        k_reg <= k_reg + VW'(1);
                    end
                end
                S_EVAL:
                begin
                    if (col_eff == dcf_pkg::COL_WHITE && depth_reg < VW'(MAX_V))
                    begin
                        u_reg     <= k_reg[AW-1:0];
                        k_reg     <= '0;
                        depth_reg <= depth_reg + VW'(1);
                        state_reg <= S_ROW;
                    end
                    else
                    begin
                        if (col_eff == dcf_pkg::COL_GRAY)
                        begin
                            found_reg  <= 1'b1;
                            cstart_reg <= k_reg[AW-1:0];
                            cend_reg   <= u_reg;
                        end
                        k_reg     <= k_reg + VW'(1);
                        state_reg <= S_SCAN;
                    end
                end
                S_POP:
                begin
                    u_reg     <= stk_rd[VW+AW-1:VW];
                    k_reg     <= stk_rd[VW-1:0];
                    state_reg <= S_ROW;
                end
                S_PATH:
                begin
                    plen_reg <= plen_reg + VW'(1);
                    if (cur_reg == cstart_reg || plen_reg + VW'(1) >= n_reg)
                    begin
                        state_reg <= S_EMIT;
                    end
                    else
                    begin
                        state_reg <= S_PWAIT;
                    end
                end
                S_PWAIT:
                begin
                    cur_reg   <= par_rd;
                    state_reg <= S_PATH;
                end
                S_EMIT:
                begin
                    if (plen_reg == '0)
                    begin
                        if (!out_v_reg || out_take)
                        begin
                            clr_reg   <= '0;
                            state_reg <= S_CLEAR;
                        end
                    end
                    else
                    begin
                        state_reg <= S_EOUT;
                    end
                end
                S_EOUT:
                begin
                    if (!out_v_reg || out_take)
                    begin
                        emit_reg <= emit_reg + VW'(1);
                        if (emit_reg == plen_reg - VW'(1))
                        begin
                            clr_reg   <= '0;
                            state_reg <= S_CLEAR;
                        end
                        else
                        begin
                            state_reg <= S_EMIT;
                        end
                    end
                end
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + VW'(1);
                    if (clr_reg == VW'(MAX_V - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = out_v_reg;
    assign m_axis_tdata  = {1'b0, out_d_reg};
    assign m_axis_tuser  = out_f_reg;
    assign m_axis_tlast  = out_l_reg;

    `DCF_ASSERT_IMP(a_no_accept_busy, clk, rst_n,
        state_reg != S_IDLE, !s_axis_tready)
    `DCF_ASSERT_NXT(a_out_hold, clk, rst_n,
        out_v_reg && !m_axis_tready, out_v_reg)
    `DCF_ASSERT_IMP(a_depth_bound, clk, rst_n,
        1'b1, depth_reg <= VW'(MAX_V))
endmodule

FILE: src/dcf_ram.sv
// ----------------------------------------------------------------------------
// dcf_ram
// Single write, single read synchronous memory with registered read data.
// ----------------------------------------------------------------------------
module dcf_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
